>>> hw/rtl/thl_pkg.sv
// thl_pkg: shared widths, codes and types for the triplet hinge loss block
// used by thl_front, thl_queue, thl_back and triplet_hinge_loss
`timescale 1ns / 1ps
`default_nettype none

package thl_pkg;

  // port field widths
  localparam int IN_W     = 16;
  localparam int OUT_W    = 47;
  localparam int MARGIN_W = 32;

  // arithmetic sizing
  localparam int FEAT_W       = 16;
  localparam int ACC_W        = 48;
  localparam int MAX_TRIPLETS = 65536;
  localparam int CNT_W        = $clog2(MAX_TRIPLETS + 1);
  localparam int MAG_W        = FEAT_W + 1;
  localparam int ED_W         = 2 * MAG_W;
  localparam int ACC_SUM_W    = ((ACC_W > ED_W) ? ACC_W : ED_W) + 1;
  localparam int BSUM_W       = 64;

  // batch mean divider, one quotient bit per cycle
  localparam int DIV_STEPS = BSUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'b1;

  typedef enum logic {
    NORM_L1 = 1'b0,
    NORM_L2 = 1'b1
  } norm_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [MARGIN_W-1:0]  data;
  } cfg_wr_t;

  // one finished triplet, as queued for the back end
  typedef struct packed {
    logic [OUT_W-1:0] term;
    logic             bend;
  } thl_entry_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/thl_front.sv
// thl_front: input request handling, configuration registers, per-element
// distances, distance accumulation and hinge term; depends on thl_pkg
`timescale 1ns / 1ps
`default_nettype none

module thl_front
  import thl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_wr_t                  cfg_i,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [IN_W-1:0]   in_query_value,
  input  logic signed [IN_W-1:0]   in_similar_value,
  input  logic signed [IN_W-1:0]   in_dissimilar_value,
  input  logic                     in_vector_end,
  input  logic                     in_batch_end,
  input  q_status_t                q_stat_i,
  output logic                     push_o,
  output thl_entry_t               push_data_o
);

  norm_t               norm_r;
  logic [MARGIN_W-1:0] margin_r;

  logic                accept;
  logic [MAG_W-1:0]    pos_mag, neg_mag;
  logic [ED_W-1:0]     pos_ed, neg_ed;

  logic                s1_v_r, s1_vend_r, s1_bend_r;
  logic [ED_W-1:0]     s1_pos_r, s1_neg_r;

  logic [ACC_W-1:0]    pos_acc_r, neg_acc_r, pos_acc_nxt, neg_acc_nxt;
  logic [ACC_W-1:0]    pos_sat, neg_sat;
  logic [ACC_SUM_W-1:0] pos_sum, neg_sum;

  logic                s2_v_r, s2_bend_r;
  logic [ACC_W-1:0]    s2_pos_r, s2_neg_r;
  logic signed [63:0]  diff;

  logic [1:0]          pending;
  logic [Q_CNT_W:0]    used;

  // configuration, to be written only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r   <= NORM_L2;
      margin_r <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_NORM:   norm_r   <= norm_t'(cfg_i.data[0]);
        CFG_MARGIN: margin_r <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  // credit check: every request in the pipe that ends a vector owns a queue slot
  assign pending  = {1'b0, s1_v_r & s1_vend_r} + {1'b0, s2_v_r};
  assign used     = (Q_CNT_W + 1)'(q_stat_i.count) + (Q_CNT_W + 1)'(pending);
  assign in_stall = (used >= (Q_CNT_W + 1)'(Q_DEPTH));
  assign accept   = in_valid && !in_stall;

  function automatic logic [MAG_W-1:0] abs_diff(input logic [FEAT_W-1:0] a,
                                                input logic [FEAT_W-1:0] b);
    logic signed [MAG_W-1:0] d;
    d = $signed({a[FEAT_W-1], a}) - $signed({b[FEAT_W-1], b});
    return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  // stage 0: element distances
  always_comb begin
    pos_mag = abs_diff(in_query_value[FEAT_W-1:0], in_similar_value[FEAT_W-1:0]);
    neg_mag = abs_diff(in_query_value[FEAT_W-1:0], in_dissimilar_value[FEAT_W-1:0]);
    if (norm_r == NORM_L2) begin
      pos_ed = ED_W'(pos_mag) * ED_W'(pos_mag);
      neg_ed = ED_W'(neg_mag) * ED_W'(neg_mag);
    end else begin
      pos_ed = ED_W'(pos_mag);
      neg_ed = ED_W'(neg_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_vend_r <= in_vector_end;
      s1_bend_r <= in_batch_end;
      s1_pos_r  <= pos_ed;
      s1_neg_r  <= neg_ed;
    end
  end

  // stage 1: saturating accumulation
  always_comb begin
    pos_sum = ACC_SUM_W'(pos_acc_r) + ACC_SUM_W'(s1_pos_r);
    neg_sum = ACC_SUM_W'(neg_acc_r) + ACC_SUM_W'(s1_neg_r);
    pos_sat = (|pos_sum[ACC_SUM_W-1:ACC_W]) ? {ACC_W{1'b1}} : pos_sum[ACC_W-1:0];
    neg_sat = (|neg_sum[ACC_SUM_W-1:ACC_W]) ? {ACC_W{1'b1}} : neg_sum[ACC_W-1:0];
    pos_acc_nxt = pos_acc_r;
    neg_acc_nxt = neg_acc_r;
    if (s1_v_r) begin
      pos_acc_nxt = s1_vend_r ? '0 : pos_sat;
      neg_acc_nxt = s1_vend_r ? '0 : neg_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_acc_r <= '0;
      neg_acc_r <= '0;
      s2_v_r    <= 1'b0;
    end else begin
      pos_acc_r <= pos_acc_nxt;
      neg_acc_r <= neg_acc_nxt;
      s2_v_r    <= s1_v_r && s1_vend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_vend_r) begin
      s2_pos_r  <= pos_sat;
      s2_neg_r  <= neg_sat;
      s2_bend_r <= s1_bend_r;
    end
  end

  // stage 2: hinge term
  always_comb begin
    diff = $signed(64'(s2_pos_r)) - $signed(64'(s2_neg_r)) + $signed(64'(margin_r));
    if (diff <= 64'sd0) begin
      push_data_o.term = '0;
    end else if (diff > $signed(64'(OUT_MAX))) begin
      push_data_o.term = OUT_MAX;
    end else begin
      push_data_o.term = diff[OUT_W-1:0];
    end
    push_data_o.bend = s2_bend_r;
  end

  assign push_o = s2_v_r;

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_vend_r) |=> (pos_acc_r == '0 && neg_acc_r == '0))
    else $error("distance accumulators not cleared after vector end");

  a_no_overcommit: assert property (@(posedge clk) disable iff (!rst_n)
    used <= (Q_CNT_W + 1)'(Q_DEPTH))
    else $error("queue credits overcommitted");

endmodule

`default_nettype wire

>>> hw/rtl/thl_queue.sv
// thl_queue: small flop queue of finished triplet terms between front and back
// depends on thl_pkg
`timescale 1ns / 1ps
`default_nettype none

module thl_queue
  import thl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  thl_entry_t push_data_i,
  input  logic       pop_i,
  output thl_entry_t head_o,
  output q_status_t  stat_o
);

  thl_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  assign head_o       = mem_r[rd_ptr_r];
  assign stat_o.count = count_r;
  assign stat_o.empty = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (count_r != Q_CNT_W'(Q_DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hw/rtl/thl_back.sv
// thl_back: batch sum and triplet count, bit-serial batch mean divider and
// output register; depends on thl_pkg
`timescale 1ns / 1ps
`default_nettype none

module thl_back
  import thl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  thl_entry_t       head_i,
  input  q_status_t        q_stat_i,
  output logic             pop_o,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_triplet_term,
  output logic [OUT_W-1:0] out_mean_loss,
  output logic             out_batch_done
);

  bk_state_t              state_r, state_nxt;
  logic [BSUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [BSUM_W:0]        sum_add;
  logic [BSUM_W-1:0]      sum_sat;
  logic [CNT_W-1:0]       cnt_inc;

  logic [BSUM_W-1:0]      dvd_r;
  logic [CNT_W-1:0]       dvs_r, rem_r;
  logic [DIV_CNT_W-1:0]   step_r;
  logic [OUT_W-1:0]       hold_term_r;
  logic [CNT_W:0]         shifted, trial;
  logic                   qbit;
  logic [OUT_W-1:0]       mean_sat;

  logic                   out_valid_r, out_done_r;
  logic [OUT_W-1:0]       out_term_r, out_mean_r;
  logic                   out_free;
  logic                   div_start, load_plain, load_mean;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_stat_i.empty && head_i.bend) state_nxt = BK_DIV;
      BK_DIV:  if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = BK_DONE;
      BK_DONE: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o      = 1'b0;
    div_start  = 1'b0;
    load_plain = 1'b0;
    load_mean  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          if (head_i.bend) begin
            pop_o     = 1'b1;
            div_start = 1'b1;
          end else if (out_free) begin
            pop_o      = 1'b1;
            load_plain = 1'b1;
          end
        end
      end
      BK_DIV:  ;
      BK_DONE: load_mean = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // batch sum and count
  always_comb begin
    sum_add = {1'b0, sum_r} + (BSUM_W + 1)'(head_i.term);
    sum_sat = sum_add[BSUM_W] ? {BSUM_W{1'b1}} : sum_add[BSUM_W-1:0];
    cnt_inc = (cnt_r < CNT_W'(MAX_TRIPLETS)) ? cnt_r + 1'b1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (pop_o) begin
      sum_r <= head_i.bend ? '0 : sum_sat;
      cnt_r <= head_i.bend ? '0 : cnt_inc;
    end
  end

  // restoring divider: quotient bits shift into the dividend register
  always_comb begin
    shifted  = {rem_r, dvd_r[BSUM_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    qbit     = (shifted >= {1'b0, dvs_r});
    mean_sat = (|dvd_r[BSUM_W-1:OUT_W]) ? OUT_MAX : dvd_r[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      dvd_r       <= sum_sat;
      dvs_r       <= cnt_inc;
      rem_r       <= '0;
      step_r      <= '0;
      hold_term_r <= head_i.term;
    end else if (state_r == BK_DIV) begin
      dvd_r  <= {dvd_r[BSUM_W-2:0], qbit};
      rem_r  <= qbit ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_r <= step_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_plain || load_mean) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_plain) begin
      out_term_r <= head_i.term;
      out_mean_r <= '0;
      out_done_r <= 1'b0;
    end else if (load_mean) begin
      out_term_r <= hold_term_r;
      out_mean_r <= mean_sat;
      out_done_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_triplet_term = out_term_r;
  assign out_mean_loss    = out_mean_r;
  assign out_batch_done   = out_done_r;

  a_mean_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_r) |-> (out_mean_r == '0))
    else $error("mean present on a result that does not close a batch");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (dvs_r != '0))
    else $error("batch mean divided by zero count");

endmodule

`default_nettype wire

>>> hw/rtl/triplet_hinge_loss.sv
// triplet_hinge_loss: top level, front end, term queue and back end
// depends on thl_pkg, thl_front, thl_queue, thl_back
//
// Usage: each input request carries one element of the query, similar and
// dissimilar vectors (signed Q4.12) plus vector_end / batch_end flags.
// A request is taken when in_valid is high and in_stall is low; results leave
// when out_valid is high and out_stall is low. One result per vector_end.
// Configuration (index 0 distance_norm, index 1 margin) is written through
// cfg_valid / cfg_ready, with cfg_ready always high; write only while idle.
// Throughput: one element per cycle while in_stall is low. The front end is a 3-stage pipe
// (distance, accumulate, hinge) feeding a 4-entry queue.
// A plain triplet result passes the stage 1 and 2 registers, a queue entry
// and the output register; a batch-closing result also runs through the
// bit-serial mean divider in the back end, while the queue keeps taking terms.
// in_stall rises only when the queue and the pipe hold as many finished
// vectors as the queue has entries, i.e. when the output stalls for long
// or several short vectors follow a batch end.
// Reset (rst_n low, synchronous) clears the distance accumulators, the batch sum and
// count, the queue and the output register, and sets L2 norm, margin 0.
`timescale 1ns / 1ps
`default_nettype none

module triplet_hinge_loss
  import thl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [MARGIN_W-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] in_query_value,
  input  logic signed [IN_W-1:0] in_similar_value,
  input  logic signed [IN_W-1:0] in_dissimilar_value,
  input  logic                   in_vector_end,
  input  logic                   in_batch_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_W-1:0]       out_triplet_term,
  output logic [OUT_W-1:0]       out_mean_loss,
  output logic                   out_batch_done
);

  cfg_wr_t    cfg_wr;
  logic       push, pop;
  thl_entry_t push_data, head;
  q_status_t  q_stat;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  thl_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_i               (cfg_wr),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_query_value      (in_query_value),
    .in_similar_value    (in_similar_value),
    .in_dissimilar_value (in_dissimilar_value),
    .in_vector_end       (in_vector_end),
    .in_batch_end        (in_batch_end),
    .q_stat_i            (q_stat),
    .push_o              (push),
    .push_data_o         (push_data)
  );

  thl_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  thl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_i           (head),
    .q_stat_i         (q_stat),
    .pop_o            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_triplet_term (out_triplet_term),
    .out_mean_loss    (out_mean_loss),
    .out_batch_done   (out_batch_done)
  );

endmodule

`default_nettype wire
